// File: src/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg: shared definitions for the wheel speed filter
// register map, reset values and the configuration bundle
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

	localparam int CFG_W = 16;

	typedef enum logic [1:0] {
		REG_TARGET_SPEED   = 2'd0,
		REG_JUMP_LIMIT     = 2'd1,
		REG_RECOVER_MARGIN = 2'd2,
		REG_LOW_COUNT      = 2'd3
	} reg_idx_t;

	localparam logic [CFG_W-1:0] TARGET_SPEED_RST   = 16'd0;
	localparam logic [CFG_W-1:0] JUMP_LIMIT_RST     = 16'd100;
	localparam logic [CFG_W-1:0] RECOVER_MARGIN_RST = 16'd200;
	localparam logic [CFG_W-1:0] LOW_COUNT_RST      = 16'd20;

	typedef struct packed {
		logic [CFG_W-1:0] target_speed;
		logic [CFG_W-1:0] jump_limit;
		logic [CFG_W-1:0] recover_margin;
		logic [CFG_W-1:0] low_count;
	} cfg_t;

endpackage

`default_nettype wire

// File: src/wsfr_div10.sv
// ----------------------------------------------------------------------------
// wsfr_div10: signed divide by ten
// truncates toward zero, reciprocal multiply on the magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_div10 #(
	parameter int W = 20
) (
	input  wire logic signed [W-1:0] num,
	output logic signed [W-1:0]      quo
);

	localparam int K  = W + 4;
	localparam int MW = K - 2;
	localparam int PW = W + MW;
	localparam logic [K:0] POW   = (K+1)'(1) << K;
	localparam logic [K:0] MFULL = (POW + (K+1)'(9)) / (K+1)'(10);
	localparam logic [MW-1:0] M  = MFULL[MW-1:0];

	logic [W-1:0]  mag;
	logic [PW-1:0] prod;
	logic [W-1:0]  qmag;

	assign mag  = num[W-1] ? (~num + W'(1)) : num;
	// ceil(2^k/10) is exact for every magnitude of this width
	assign prod = {{MW{1'b0}}, mag} * {{W{1'b0}}, M};
	assign qmag = {2'b00, prod[PW-1:K]};
	assign quo  = num[W-1] ? $signed(~qmag + W'(1)) : $signed(qmag);

endmodule

`default_nettype wire

// File: src/wsfr_wheel.sv
// ----------------------------------------------------------------------------
// wsfr_wheel: one wheel lane
// runaway mark, low-pass filter and the lane's filtered count and mark
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_wheel #(
	parameter int CW = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire logic signed [CW-1:0]  raw,
	input  wire wsfr_pkg::cfg_t        cfg,
	input  wire logic                  flag_drop,
	output logic signed [CW-1:0]       filt,
	output logic                       flag_nxt
);

	localparam int D  = (CW + 2 > 18) ? CW + 2 : 18;
	localparam int HW = CW + 4;

	logic signed [CW-1:0] last_q;
	logic                 flag_q;

	logic signed [D-1:0]  raw_d, last_d, jump, lim, bound;
	logic                 jump_hi, flag_set, recov;
	logic signed [HW-1:0] r_h, l_h, hsum, hq;
	logic signed [CW:0]   rsum, radj, rq;

	assign raw_d  = $signed({{(D-CW){raw[CW-1]}}, raw});
	assign last_d = $signed({{(D-CW){last_q[CW-1]}}, last_q});
	assign jump   = raw_d - last_d;
	assign lim    = $signed({{(D-16){1'b0}}, cfg.jump_limit});
	// half the target plus the recovery margin
	assign bound  = $signed({{(D-17){1'b0}},
		({2'b00, cfg.target_speed[15:1]} + {1'b0, cfg.recover_margin})});

	assign jump_hi  = jump > lim;
	assign flag_set = flag_q | jump_hi;
	assign recov    = !jump_hi && (raw_d < bound) && !raw[CW-1] && (raw != '0);
	assign flag_nxt = flag_set & !recov;

	// healthy: (9*raw + last) / 10
	assign r_h  = $signed({{(HW-CW){raw[CW-1]}}, raw});
	assign l_h  = $signed({{(HW-CW){last_q[CW-1]}}, last_q});
	assign hsum = (r_h <<< 3) + r_h + l_h;

	wsfr_div10 #(.W(HW)) u_div (
		.num(hsum),
		.quo(hq)
	);

	// runaway: (raw + last) / 2 toward zero
	assign rsum = $signed({raw[CW-1], raw}) + $signed({last_q[CW-1], last_q});
	assign radj = rsum + $signed({{CW{1'b0}}, rsum[CW]});
	assign rq   = radj >>> 1;

	assign filt = flag_nxt ? rq[CW-1:0] : hq[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			flag_q <= 1'b0;
		end else if (take) begin
			last_q <= filt;
			flag_q <= flag_nxt & !flag_drop;
		end
	end

endmodule

`default_nettype wire

// File: src/wsfr_merge.sv
// ----------------------------------------------------------------------------
// wsfr_merge: merging stage
// right mark clear, combined speed, smoothing and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_merge #(
	parameter int CW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [CW-1:0] rf,
	input  wire logic signed [CW-1:0] lf,
	input  wire logic                 rflag,
	input  wire logic                 lflag,
	input  wire wsfr_pkg::cfg_t       cfg,
	output logic                      rdrop,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic signed [CW:0]        speed,
	output logic signed [CW-1:0]      rf_out,
	output logic signed [CW-1:0]      lf_out,
	output logic                      rflag_out,
	output logic                      lflag_out
);

	localparam int D  = (CW + 2 > 18) ? CW + 2 : 18;
	localparam int SW = CW + 2;
	localparam int TW = CW + 6;

	logic                 keep;
	logic signed [D-1:0]  low_d, half_d, rf_d, lf_d;

	logic                 valid_s1;
	logic signed [CW-1:0] rf_s1, lf_s1;
	logic                 rfl_s1, lfl_s1;

	logic                 out_valid_q;
	logic signed [CW:0]   speed_q;
	logic signed [CW-1:0] rf_q, lf_q;
	logic                 rfl_q, lfl_q;
	logic signed [SW-1:0] speed_last_q;

	logic                 out_free, adv, load;
	logic signed [D-1:0]  rf1_d, lf1_d;
	logic signed [SW-1:0] now;
	logic signed [TW-1:0] n_t, sl_t, tsum, tq;

	// right mark clear from this item's lane results
	assign low_d = $signed({{(D-16){1'b0}}, cfg.low_count});
	assign rf_d  = $signed({{(D-CW){rf[CW-1]}}, rf});
	assign lf_d  = $signed({{(D-CW){lf[CW-1]}}, lf});
	assign keep  = (lflag && rflag) || (lflag && rf_d < low_d) || (rflag && lf_d < low_d);
	assign rdrop = !keep;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rf_s1  <= rf;
			lf_s1  <= lf;
			rfl_s1 <= rflag & keep;
			lfl_s1 <= lflag;
		end
	end

	// combined speed
	assign half_d = $signed({{(D-15){1'b0}}, cfg.target_speed[15:1]});
	assign rf1_d  = $signed({{(D-CW){rf_s1[CW-1]}}, rf_s1});
	assign lf1_d  = $signed({{(D-CW){lf_s1[CW-1]}}, lf_s1});

	always_comb begin
		priority if (lfl_s1 && rfl_s1) begin
			now = speed_last_q;
		end else if (lfl_s1) begin
			now = (rf1_d > half_d) ? speed_last_q : $signed({rf_s1[CW-1], rf_s1, 1'b0});
		end else if (rfl_s1) begin
			now = (lf1_d > half_d) ? speed_last_q : $signed({lf_s1[CW-1], lf_s1, 1'b0});
		end else begin
			now = $signed({{2{rf_s1[CW-1]}}, rf_s1}) + $signed({{2{lf_s1[CW-1]}}, lf_s1});
		end
	end

	// smoothing: (9*now + last) / 10
	assign n_t  = $signed({{(TW-SW){now[SW-1]}}, now});
	assign sl_t = $signed({{(TW-SW){speed_last_q[SW-1]}}, speed_last_q});
	assign tsum = (n_t <<< 3) + n_t + sl_t;

	wsfr_div10 #(.W(TW)) u_div (
		.num(tsum),
		.quo(tq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			speed_last_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q  <= 1'b1;
				speed_last_q <= tq[SW-1:0];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_q <= tq[CW:0];
			rf_q    <= rf_s1;
			lf_q    <= lf_s1;
			rfl_q   <= rfl_s1;
			lfl_q   <= lfl_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign speed     = speed_q;
	assign rf_out    = rf_q;
	assign lf_out    = lf_q;
	assign rflag_out = rfl_q;
	assign lflag_out = lfl_q;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken with both stages held");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced item missing from output register");

	a_speed_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> speed_last_q[CW:0] == speed_q)
		else $error("smoothed speed state disagrees with result");

endmodule

`default_nettype wire

// File: src/wheel_speed_filter_runaway_core.sv
// ----------------------------------------------------------------------------
// wheel_speed_filter_runaway_core: wheel speed filter with runaway marks
// two wheel lanes, a merging stage and an APB-style register block
// ----------------------------------------------------------------------------
//
// channel   dir  transaction moves
// s_*       in   right_raw, left_raw
// m_*       out  speed, right_filtered, left_filtered, right_runaway, left_runaway
// apb       in   register writes and reads (target_speed, jump_limit, recover_margin,
//                low_count)
//
// one transaction a cycle while m_tready is high; merge then output register
// the wheel filters close their loop within each lane (lane divide by ten),
// the speed smoothing closes its loop in the merge stage (second divide by ten)
// arst_n clears wheel state, marks, speed state and both valid bits
// a stalled m_ side still lets one more item into the merge stage
`default_nettype none

module wheel_speed_filter_runaway_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// right_raw, left_raw
	input  wire logic [((2*COUNT_WIDTH+7)/8)*8-1:0] s_tdata,

	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// speed, right_filtered, left_filtered, right_runaway, left_runaway
	output logic [((3*COUNT_WIDTH+3+7)/8)*8-1:0]    m_tdata,

	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int CW  = COUNT_WIDTH;
	localparam int OW  = 3 * CW + 3;
	localparam int OBW = ((OW + 7) / 8) * 8;

	wsfr_pkg::cfg_t    cfg_q;
	wsfr_pkg::reg_idx_t reg_sel;
	logic              wr_en;

	logic signed [CW-1:0] right_raw, left_raw;
	logic signed [CW-1:0] rf, lf;
	logic                 rflag, lflag, rdrop, take;

	logic signed [CW:0]   speed;
	logic signed [CW-1:0] rf_out, lf_out;
	logic                 rflag_out, lflag_out;

	// register block: always ready, one write per access phase
	assign pready  = 1'b1;
	assign reg_sel = wsfr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed   <= wsfr_pkg::TARGET_SPEED_RST;
			cfg_q.jump_limit     <= wsfr_pkg::JUMP_LIMIT_RST;
			cfg_q.recover_margin <= wsfr_pkg::RECOVER_MARGIN_RST;
			cfg_q.low_count      <= wsfr_pkg::LOW_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				wsfr_pkg::REG_TARGET_SPEED:   cfg_q.target_speed   <= pwdata[15:0];
				wsfr_pkg::REG_JUMP_LIMIT:     cfg_q.jump_limit     <= pwdata[15:0];
				wsfr_pkg::REG_RECOVER_MARGIN: cfg_q.recover_margin <= pwdata[15:0];
				wsfr_pkg::REG_LOW_COUNT:      cfg_q.low_count      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			wsfr_pkg::REG_TARGET_SPEED:   prdata = {16'h0000, cfg_q.target_speed};
			wsfr_pkg::REG_JUMP_LIMIT:     prdata = {16'h0000, cfg_q.jump_limit};
			wsfr_pkg::REG_RECOVER_MARGIN: prdata = {16'h0000, cfg_q.recover_margin};
			wsfr_pkg::REG_LOW_COUNT:      prdata = {16'h0000, cfg_q.low_count};
			default:                      prdata = '0;
		endcase
	end

	// input unpacking, right count in the low bits
	assign right_raw = $signed(s_tdata[CW-1:0]);
	assign left_raw  = $signed(s_tdata[2*CW-1:CW]);
	assign take      = s_tvalid && s_tready;

	// lanes: each wheel updates its own filter state on an accepted item
	wsfr_wheel #(.CW(CW)) u_right (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.raw(right_raw),
		.cfg(cfg_q),
		.flag_drop(rdrop),
		.filt(rf),
		.flag_nxt(rflag)
	);

	// the left mark is only ever cleared by its own recovery test
	wsfr_wheel #(.CW(CW)) u_left (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.raw(left_raw),
		.cfg(cfg_q),
		.flag_drop(1'b0),
		.filt(lf),
		.flag_nxt(lflag)
	);

	// merge: right mark clear, combined and smoothed speed, output register
	wsfr_merge #(.CW(CW)) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.rf(rf),
		.lf(lf),
		.rflag(rflag),
		.lflag(lflag),
		.cfg(cfg_q),
		.rdrop(rdrop),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.speed(speed),
		.rf_out(rf_out),
		.lf_out(lf_out),
		.rflag_out(rflag_out),
		.lflag_out(lflag_out)
	);

	// result packing, speed in the low bits, zero fill to the byte
	always_comb begin
		m_tdata         = {OBW{1'b0}};
		m_tdata[OW-1:0] = {lflag_out, rflag_out, lf_out, rf_out, speed};
	end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: wheel speed filter with runaway marks
// streams encoder count pairs through the core with random idling on both
// sides, predicts every filtered reading and checks it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int CW = 16;

	// one result transaction, packed so that it lines up with m_tdata
	// from the lowest bit up: speed, right_filtered, left_filtered,
	// right_runaway, left_runaway
	typedef struct packed {
		logic                 left_runaway;
		logic                 right_runaway;
		logic signed [CW-1:0] left_filtered;
		logic signed [CW-1:0] right_filtered;
		logic signed [CW:0]   speed;
	} wheel_reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// right_raw, left_raw
	logic [31:0] s_tdata = '0;

	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// speed, right_filtered, left_filtered, right_runaway, left_runaway
	logic [55:0] m_tdata;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the register block and of the filter state
	wsfr_pkg::cfg_t cfg_model = '{wsfr_pkg::TARGET_SPEED_RST, wsfr_pkg::JUMP_LIMIT_RST,
		wsfr_pkg::RECOVER_MARGIN_RST, wsfr_pkg::LOW_COUNT_RST};
	longint right_prev = 0;
	longint left_prev = 0;
	longint speed_prev = 0;
	bit     right_mark = 1'b0;
	bit     left_mark = 1'b0;

	// readings still owed by the core, oldest first
	wheel_reading_t expected_readings[$];

	// when set, neither side idles
	bit steady = 1'b0;

	int error_count = 0;
	int pairs_sent = 0;
	int readings_checked = 0;
	int reg_writes = 0;
	int right_marks_seen = 0;
	int left_marks_seen = 0;
	int both_marks_seen = 0;

	wheel_speed_filter_runaway_core #(
		.COUNT_WIDTH(CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 10 time unit period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// generous upper bound on the whole run
	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// one wheel: update its runaway mark, then low-pass its count
	function automatic longint filter_wheel(input longint raw, inout longint last,
			inout bit mark, input longint half);
		longint jump;
		longint lim;
		longint filt;
		lim = longint'(cfg_model.jump_limit);
		jump = raw - last;
		if (jump > lim)
			mark = 1'b1;
		// recovery needs a small jump and a plausible positive count
		if (mark && jump <= lim && raw < half + longint'(cfg_model.recover_margin) && raw > 0)
			mark = 1'b0;
		// integer division truncates toward zero, as the hardware does
		if (mark)
			filt = (raw + last) / 2;
		else
			filt = (9 * raw + last) / 10;
		last = filt;
		return filt;
	endfunction

	function automatic wheel_reading_t predict_filter_step(input logic signed [CW-1:0] right_raw,
			input logic signed [CW-1:0] left_raw);
		longint half;
		longint lowc;
		longint rraw;
		longint lraw;
		longint right_filt;
		longint left_filt;
		longint combined;
		wheel_reading_t res;
		half = longint'(cfg_model.target_speed >> 1);
		lowc = longint'(cfg_model.low_count);
		rraw = right_raw;
		lraw = left_raw;
		right_filt = filter_wheel(rraw, right_prev, right_mark, half);
		left_filt = filter_wheel(lraw, left_prev, left_mark, half);

		// only the right mark is dropped here, unless a stalled or runaway
		// partner keeps it
		if (!((left_mark && right_mark) || (left_mark && right_filt < lowc) ||
				(right_mark && left_filt < lowc)))
			right_mark = 1'b0;

		if (left_mark && right_mark)
			combined = speed_prev;
		else if (left_mark)
			combined = (right_filt > half) ? speed_prev : 2 * right_filt;
		else if (right_mark)
			combined = (left_filt > half) ? speed_prev : 2 * left_filt;
		else
			combined = left_filt + right_filt;

		combined = (9 * combined + speed_prev) / 10;
		speed_prev = combined;

		res.speed = combined[CW:0];
		res.right_filtered = right_filt[CW-1:0];
		res.left_filtered = left_filt[CW-1:0];
		res.right_runaway = right_mark;
		res.left_runaway = left_mark;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic int draw_wait();
		return steady ? 0 : int'($urandom_range(0, 15));
	endfunction

	// a count for one wheel, mostly near its last filtered value so that
	// marks are set and cleared often, with boundaries and noise mixed in
	function automatic logic signed [CW-1:0] pick_count(input longint prev);
		longint lim;
		longint bound;
		longint val;
		lim = longint'(cfg_model.jump_limit);
		bound = longint'(cfg_model.target_speed >> 1) + longint'(cfg_model.recover_margin);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				val = prev + longint'($urandom_range(0, 32'(2 * lim))) - lim;
			end
			4: begin
				val = prev + lim + 1 + longint'($urandom_range(0, 63));
			end
			5: begin
				// jump exactly at the limit
				val = prev + lim;
			end
			6: begin
				// inside the recovery window
				val = (bound > 1) ? longint'($urandom_range(1, 32'(bound - 1))) : 1;
			end
			7: begin
				// on or just either side of the recovery bound
				val = bound - 1 + longint'($urandom_range(0, 2));
			end
			8: begin
				val = longint'($urandom_range(0, 65535));
			end
			default: begin
				val = longint'($urandom_range(0, 2)) - 1;
			end
		endcase
		return val[CW-1:0];
	endfunction

	// one count pair on the slave side; the prediction is made at the
	// accepting edge, when the configuration is known to be in force
	task automatic send_counts(input logic signed [CW-1:0] right_raw,
			input logic signed [CW-1:0] left_raw);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {left_raw, right_raw};
		do @(posedge clk); while (!s_tready);
		expected_readings.push_back(predict_filter_step(right_raw, left_raw));
		pairs_sent++;
	endtask

	// stop sending and let every owed reading come out, plus the pipeline depth
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one apb transfer: setup cycle, then access until pready
	task automatic apb_transfer(input bit write_op, input wsfr_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write_op;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input wsfr_pkg::reg_idx_t idx);
		logic [31:0] rdata;
		logic [15:0] want;
		case (idx)
			wsfr_pkg::REG_TARGET_SPEED:   want = cfg_model.target_speed;
			wsfr_pkg::REG_JUMP_LIMIT:     want = cfg_model.jump_limit;
			wsfr_pkg::REG_RECOVER_MARGIN: want = cfg_model.recover_margin;
			default:                      want = cfg_model.low_count;
		endcase
		apb_transfer(1'b0, idx, 32'd0, rdata);
		if (rdata !== {16'd0, want}) begin
			$display("%0t: register %s readback mismatch, expected %0d, got %0d",
				$time, idx.name(), want, rdata);
			error_count++;
		end
	endtask

	// write a register while the core is idle, then read it back
	task automatic program_register(input wsfr_pkg::reg_idx_t idx, input logic [15:0] value);
		logic [31:0] rdata;
		apb_transfer(1'b1, idx, {16'd0, value}, rdata);
		case (idx)
			wsfr_pkg::REG_TARGET_SPEED:   cfg_model.target_speed = value;
			wsfr_pkg::REG_JUMP_LIMIT:     cfg_model.jump_limit = value;
			wsfr_pkg::REG_RECOVER_MARGIN: cfg_model.recover_margin = value;
			default:                      cfg_model.low_count = value;
		endcase
		reg_writes++;
		check_register(idx);
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	task automatic report_field(input string field, input longint want, input longint seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
			error_count++;
		end
	endtask

	// draws a stall before every reading, then checks the transaction
	// against the oldest prediction
	initial begin : reading_checker
		int stall;
		wheel_reading_t got;
		wheel_reading_t want;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = wheel_reading_t'(m_tdata[50:0]);
			if (expected_readings.size() == 0) begin
				$display("%0t: reading with none expected, got %h", $time, m_tdata);
				error_count++;
			end else begin
				want = expected_readings.pop_front();
				report_field("speed", longint'(want.speed), longint'(got.speed));
				report_field("right_filtered", longint'(want.right_filtered),
					longint'(got.right_filtered));
				report_field("left_filtered", longint'(want.left_filtered),
					longint'(got.left_filtered));
				report_field("right_runaway", longint'(want.right_runaway),
					longint'(got.right_runaway));
				report_field("left_runaway", longint'(want.left_runaway),
					longint'(got.left_runaway));
				readings_checked++;
				if (want.right_runaway && want.left_runaway)
					both_marks_seen++;
				else if (want.right_runaway)
					right_marks_seen++;
				else if (want.left_runaway)
					left_marks_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_register_defaults();
		check_register(wsfr_pkg::REG_TARGET_SPEED);
		check_register(wsfr_pkg::REG_JUMP_LIMIT);
		check_register(wsfr_pkg::REG_RECOVER_MARGIN);
		check_register(wsfr_pkg::REG_LOW_COUNT);
	endtask

	// full-scale counts on both wheels with the reset configuration
	task automatic test_count_extremes();
		send_counts(16'sd0, 16'sd0);
		send_counts(16'sh7FFF, 16'sh8000);
		send_counts(16'sh8000, 16'sh7FFF);
		send_counts(-16'sd1, -16'sd1);
		send_counts(16'sh7FFF, 16'sh7FFF);
		send_counts(16'sh8000, 16'sh8000);
		send_counts(16'sd1, 16'sd1);
		settle_block();
	endtask

	// walks the mark logic: jump threshold, lone-wheel fallback on either
	// side, recovery, the one-sided clear of the right mark, both runaway
	task automatic test_runaway_marks();
		program_register(wsfr_pkg::REG_TARGET_SPEED, 16'd400);
		program_register(wsfr_pkg::REG_JUMP_LIMIT, 16'hFFFF);
		program_register(wsfr_pkg::REG_RECOVER_MARGIN, 16'd200);
		program_register(wsfr_pkg::REG_LOW_COUNT, 16'd20);
		// no jump can mark here, so both wheels settle near 50
		repeat (4) send_counts(16'sd50, 16'sd50);
		settle_block();
		program_register(wsfr_pkg::REG_JUMP_LIMIT, 16'd100);

		// a jump equal to the limit stays healthy, one above marks the left
		send_counts(16'(right_prev + 100), 16'(left_prev + 101));
		// a zero count holds the left mark; right climbs past half the target
		repeat (2) send_counts(16'(right_prev + 100), 16'sd0);
		// small positive count inside the window clears the left mark
		send_counts(16'(right_prev), 16'sd1);
		// right runs away while the left is nearly stalled: right mark kept
		send_counts(16'(right_prev + 101), 16'sd0);
		// left picks up again, so the right mark is dropped after filtering
		send_counts(16'(right_prev + 101), 16'(left_prev + 100));
		// both run away, then non-positive counts keep both marks
		send_counts(16'(right_prev + 101), 16'(left_prev + 101));
		send_counts(-16'sd5, -16'sd5);
		settle_block();
	endtask

	// phases of random traffic, each under its own register setting
	task automatic test_random_traffic();
		logic [15:0] set_speed;
		logic [15:0] set_jump;
		logic [15:0] set_margin;
		logic [15:0] set_low;
		for (int phase_no = 0; phase_no < 10; phase_no++) begin
			case (phase_no)
				0: begin
					set_speed = 16'd0;
					set_jump = 16'd0;
					set_margin = 16'd0;
					set_low = 16'd0;
				end
				1: begin
					set_speed = 16'hFFFF;
					set_jump = 16'hFFFF;
					set_margin = 16'hFFFF;
					set_low = 16'hFFFF;
				end
				2: begin
					set_speed = 16'($urandom_range(0, 65535));
					set_jump = 16'($urandom_range(0, 65535));
					set_margin = 16'($urandom_range(0, 65535));
					set_low = 16'($urandom_range(0, 65535));
				end
				default: begin
					// realistic ranges where marks come and go
					set_speed = 16'($urandom_range(0, 4000));
					set_jump = 16'($urandom_range(0, 600));
					set_margin = 16'($urandom_range(0, 600));
					set_low = 16'($urandom_range(0, 300));
				end
			endcase
			program_register(wsfr_pkg::REG_TARGET_SPEED, set_speed);
			program_register(wsfr_pkg::REG_JUMP_LIMIT, set_jump);
			program_register(wsfr_pkg::REG_RECOVER_MARGIN, set_margin);
			program_register(wsfr_pkg::REG_LOW_COUNT, set_low);
			// every fourth phase runs back to back on both sides
			steady = (phase_no % 4 == 3);
			repeat (60) send_counts(pick_count(right_prev), pick_count(left_prev));
			settle_block();
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		// reset held at the start, released once
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_defaults();
		test_count_extremes();
		test_runaway_marks();
		test_random_traffic();
		settle_block();

		$display("sent %0d count pairs under %0d register writes, %0d readings compared",
			pairs_sent, reg_writes, readings_checked);
		$display("readings with runaway marks: right only %0d, left only %0d, both %0d",
			right_marks_seen, left_marks_seen, both_marks_seen);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: wheel_speed_filter_runaway_core.f
src/wsfr_pkg.sv
src/wsfr_div10.sv
src/wsfr_wheel.sv
src/wsfr_merge.sv
src/wheel_speed_filter_runaway_core.sv
verif/testbench.sv
